FILE: hw/rtl/afs_pkg.sv
// Package for the assembly flow shop search block.
// Holds the controller state type, command/status structs and fixed widths.
package afs_pkg;

   localparam int FIN_BITS = 21;
   localparam logic [FIN_BITS-1:0] FIN_MAX = '1;
   localparam int JOB_BITS = 4;
   localparam int MACH_BITS = 4;

   // Item kinds on the input channel.
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_START = 1'b1;

   // Register indexes on the configuration channel.
   localparam logic [0:0] CSR_NUM_JOBS = 1'b0;
   localparam logic [0:0] CSR_NUM_MACHINES = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_MACH,
      ST_LEAF,
      ST_BACK,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic init;          // clear search state for a new start item
      logic pick;          // select next free job at current level
      logic mach_step;     // process one machine of the extension
      logic leaf;          // compare leaf makespan against best
      logic back;          // release job and pop one level
      logic emit_load;     // load next output position
   } cmd_type;

   typedef struct packed {
      logic found;         // a free job exists below the last tried one
      logic mach_done;     // all machines of the extension done
      logic at_leaf;       // depth equals job count
      logic at_root;       // depth is zero
      logic emit_last;     // output position is the last one
   } status_type;

endpackage

FILE: hw/rtl/afs_datapath.sv
// Datapath of the flow shop search: time tables, finish-time stack, sequence.
// Depends on afs_pkg; driven by afs_ctrl through cmd_type and status_type.
module afs_datapath #(
   parameter int MAX_JOBS = 10,
   parameter int MAX_MACHINES = 10,
   parameter int TIME_BITS = 16
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [afs_pkg::JOB_BITS-1:0] wr_job,
   input  logic [afs_pkg::MACH_BITS-1:0] wr_mach,
   input  logic [15:0] wr_proc,
   input  logic [15:0] wr_setup,
   input  logic [afs_pkg::JOB_BITS-1:0] run_jobs,
   input  logic [afs_pkg::MACH_BITS-1:0] run_machs,
   input  afs_pkg::cmd_type cmd,
   output afs_pkg::status_type status,
   output logic [afs_pkg::JOB_BITS-1:0] out_pos,
   output logic [afs_pkg::JOB_BITS-1:0] out_job,
   output logic [afs_pkg::FIN_BITS-1:0] out_best
);
   import afs_pkg::*;

   localparam int TDEPTH = MAX_JOBS * MAX_MACHINES;
   localparam int TA = $clog2(TDEPTH);
   localparam int LDEPTH = (MAX_JOBS + 1) * MAX_MACHINES;
   localparam int LA = $clog2(LDEPTH);
   localparam int MB = $clog2(MAX_MACHINES);

   logic [TIME_BITS-1:0] proc_mem [TDEPTH];
   logic [TIME_BITS-1:0] setup_mem [TDEPTH];
   logic [FIN_BITS-1:0] fin_mem [LDEPTH];

   logic [JOB_BITS-1:0] seq_ff [MAX_JOBS];
   logic [JOB_BITS-1:0] best_seq_ff [MAX_JOBS];
   logic [MAX_JOBS-1:0] used_ff, used_in;
   logic [JOB_BITS-1:0] depth_ff, depth_in;
   // Next candidate bound per level: jobs below this value remain to be tried.
   logic [JOB_BITS:0] bound_ff [MAX_JOBS];
   logic [MB:0] mach_ff, mach_in;
   logic [FIN_BITS-1:0] top_ff, top_in;
   logic [FIN_BITS-1:0] best_ff;
   logic best_valid_ff;
   logic [JOB_BITS-1:0] pos_ff;

   // Table and stack read data (registered reads).
   logic [TIME_BITS-1:0] p_rd_ff, s_rd_ff;
   logic [FIN_BITS-1:0] prev_rd_ff;
   logic rd_valid_ff;

   logic [TA-1:0] wr_addr;
   assign wr_addr = TA'(32'(wr_job) * MAX_MACHINES + 32'(wr_mach));

   always_ff @(posedge clock) begin
      if (wr_en && 32'(wr_job) < MAX_JOBS && 32'(wr_mach) < MAX_MACHINES) begin
         proc_mem[wr_addr] <= TIME_BITS'(wr_proc);
         setup_mem[wr_addr] <= TIME_BITS'(wr_setup);
      end
   end

   // Free job search below the current bound and the job count, highest first.
   logic [JOB_BITS:0] cur_bound;
   logic found;
   logic [JOB_BITS-1:0] pick_job;
   always_comb begin
      cur_bound = bound_ff[depth_ff[JOB_BITS-1:0] < JOB_BITS'(MAX_JOBS) ?
                  depth_ff : '0];
      found = 1'b0;
      pick_job = '0;
      for (int j = 0; j < MAX_JOBS; j++) begin
         if (!used_ff[j] && (JOB_BITS+1)'(j) < cur_bound &&
             JOB_BITS'(j) < run_jobs) begin
            found = 1'b1;
            pick_job = JOB_BITS'(j);
         end
      end
   end

   // Current job being extended and its level.
   logic [JOB_BITS-1:0] ext_job;
   assign ext_job = seq_ff[depth_ff == '0 ? '0 : depth_ff - 1'b1];
   logic [JOB_BITS-1:0] ext_lvl;
   assign ext_lvl = depth_ff - 1'b1;
   logic [MACH_BITS-1:0] last_m;
   assign last_m = run_machs - 1'b1;

   // Read addresses for the machine currently addressed.
   logic [MB-1:0] m_idx;
   assign m_idx = mach_ff[MB-1:0];
   logic [TA-1:0] t_rd_addr;
   logic [LA-1:0] l_rd_addr, l_wr_addr;
   assign t_rd_addr = TA'(32'(ext_job) * MAX_MACHINES + 32'(m_idx));
   assign l_rd_addr = LA'(32'(ext_lvl) * MAX_MACHINES + 32'(m_idx));
   logic [MB:0] mach_prev;
   assign mach_prev = mach_ff - 1'b1;
   assign l_wr_addr = LA'(32'(depth_ff) * MAX_MACHINES + 32'(mach_prev[MB-1:0]));

   // One machine update per cycle, in the cycle after its reads issue.
   function automatic logic [FIN_BITS-1:0] sat(input logic [FIN_BITS:0] v);
      return v[FIN_BITS] ? FIN_MAX : v[FIN_BITS-1:0];
   endfunction
   logic [FIN_BITS-1:0] ps, nf, asm_a;
   logic is_last;
   always_comb begin
      is_last = (mach_prev[MACH_BITS-1:0] == last_m);
      ps = sat({1'b0, FIN_BITS'(p_rd_ff)} + {1'b0, FIN_BITS'(s_rd_ff)});
      asm_a = sat({1'b0, prev_rd_ff} + {1'b0, FIN_BITS'(s_rd_ff)});
      if (top_ff > asm_a) asm_a = top_ff;
      if (is_last) nf = sat({1'b0, asm_a} + {1'b0, FIN_BITS'(p_rd_ff)});
      else nf = sat({1'b0, prev_rd_ff} + {1'b0, ps});
   end

   logic [FIN_BITS-1:0] leaf_mk;
   logic [FIN_BITS-1:0] leaf_rd_ff;

   always_ff @(posedge clock) begin
      p_rd_ff <= proc_mem[t_rd_addr];
      s_rd_ff <= setup_mem[t_rd_addr];
      prev_rd_ff <= (ext_lvl == '0) ? '0 : fin_mem[l_rd_addr];
      leaf_rd_ff <= fin_mem[LA'(32'(depth_ff) * MAX_MACHINES + 32'(last_m))];
      if (cmd.mach_step && rd_valid_ff) fin_mem[l_wr_addr] <= nf;
   end
   assign leaf_mk = leaf_rd_ff;

   always_comb begin
      mach_in = mach_ff;
      top_in = top_ff;
      used_in = used_ff;
      depth_in = depth_ff;
      if (cmd.init) begin
         used_in = '0;
         depth_in = '0;
      end else if (cmd.pick) begin
         used_in[pick_job] = 1'b1;
         depth_in = depth_ff + 1'b1;
         mach_in = '0;
         top_in = '0;
      end else if (cmd.mach_step) begin
         mach_in = mach_ff + 1'b1;
         if (rd_valid_ff && !is_last && nf > top_ff) top_in = nf;
      end else if (cmd.back) begin
         used_in[ext_job] = 1'b0;
         depth_in = depth_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      mach_ff <= mach_in;
      top_ff <= top_in;
      used_ff <= used_in;
      depth_ff <= depth_in;
      rd_valid_ff <= cmd.mach_step && !(mach_ff > (MB+1)'(last_m));
      if (cmd.pick) begin
         seq_ff[depth_ff] <= pick_job;
         bound_ff[depth_ff] <= {1'b0, pick_job};
         if (32'(depth_ff) + 1 < MAX_JOBS)
            bound_ff[depth_ff + 1'b1] <= {1'b0, run_jobs};
      end
      if (cmd.init) begin
         // The job count is taken at this same edge, so the root level starts
         // open and the pick logic limits it by the job count.
         bound_ff[0] <= '1;
         best_valid_ff <= 1'b0;
         best_ff <= FIN_MAX;
         pos_ff <= '0;
      end
      if (cmd.leaf && (!best_valid_ff || leaf_mk < best_ff)) begin
         best_ff <= leaf_mk;
         best_valid_ff <= 1'b1;
         for (int k = 0; k < MAX_JOBS; k++) best_seq_ff[k] <= seq_ff[k];
      end
      if (cmd.emit_load) pos_ff <= pos_ff + 1'b1;
   end

   assign status.found = found;
   assign status.mach_done = (mach_ff == (MB+1)'(run_machs) + 1'b1);
   assign status.at_leaf = (depth_ff == run_jobs);
   assign status.at_root = (depth_ff == '0);
   assign status.emit_last = (pos_ff + 1'b1 == run_jobs);
   assign out_pos = pos_ff;
   assign out_job = best_seq_ff[pos_ff];
   assign out_best = best_ff;
endmodule

FILE: hw/rtl/afs_ctrl.sv
// Controller state machine of the flow shop search.
// Depends on afs_pkg; issues cmd_type to afs_datapath and reads status_type.
module afs_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic zero_jobs,
   input  logic out_stall,
   input  afs_pkg::status_type status,
   output afs_pkg::cmd_type cmd,
   output logic busy,
   output logic out_valid
);
   import afs_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (start && !zero_jobs) state_in = ST_EXPAND;
         ST_EXPAND: begin
            if (status.at_leaf) state_in = ST_LEAF;
            else if (status.found) state_in = ST_MACH;
            else if (status.at_root) state_in = ST_EMIT;
            else state_in = ST_BACK;
         end
         ST_MACH:   if (status.mach_done) state_in = ST_EXPAND;
         ST_LEAF:   state_in = ST_BACK;
         ST_BACK:   state_in = ST_EXPAND;
         ST_EMIT:   if (!out_stall && status.emit_last) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE:   cmd.init = start;
         ST_EXPAND: cmd.pick = !status.at_leaf && status.found;
         ST_MACH:   cmd.mach_step = 1'b1;
         ST_LEAF:   cmd.leaf = 1'b1;
         ST_BACK:   cmd.back = 1'b1;
         ST_EMIT:   cmd.emit_load = !out_stall;
         default:   cmd = '0;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);
   assign out_valid = (state_ff == ST_EMIT);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule

FILE: hw/rtl/assembly_flow_shop_exhaustive_search.sv
// Two-stage assembly flow shop, exhaustive permutation search.
// A start item walks all num_jobs! orders, extending each tree node with the
// one-machine-per-cycle update loop, then emits one result per cycle while
// rsp_stall is low. Items are handled one at a time.
// Reset (synchronous, active high) idles the controller and restores the
// registers to num_jobs 10 and num_machines 4; the time tables are not cleared.
module assembly_flow_shop_exhaustive_search #(
   parameter int MAX_JOBS = 10,
   parameter int MAX_MACHINES = 10,
   parameter int TIME_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_req_type,
   input  logic [3:0] req_job_index,
   input  logic [3:0] req_machine_index,
   input  logic [15:0] req_processing_time,
   input  logic [15:0] req_setup_time,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [3:0] rsp_position,
   output logic [3:0] rsp_job_number,
   output logic [20:0] rsp_best_makespan,
   output logic rsp_last_in_run,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [0:0] csr_index,
   input  logic [3:0] csr_data
);
   import afs_pkg::*;

   logic [3:0] num_jobs_ff, num_machs_ff;
   logic [3:0] run_jobs_ff, run_machs_ff;
   logic busy, accept, start;
   cmd_type cmd;
   status_type status;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         num_jobs_ff <= 4'd10;
         num_machs_ff <= 4'd4;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_NUM_JOBS) num_jobs_ff <= csr_data;
         else num_machs_ff <= csr_data;
      end
   end

   assign req_stall = busy;
   assign accept = req_valid && !req_stall;
   assign start = accept && (req_req_type == REQ_START);

   always_ff @(posedge clock) begin
      if (start) begin
         run_jobs_ff <= (32'(num_jobs_ff) > MAX_JOBS) ? 4'(MAX_JOBS) : num_jobs_ff;
         run_machs_ff <= (num_machs_ff == '0) ? 4'd1 :
            ((32'(num_machs_ff) > MAX_MACHINES) ? 4'(MAX_MACHINES) : num_machs_ff);
      end
   end

   afs_datapath #(.MAX_JOBS(MAX_JOBS), .MAX_MACHINES(MAX_MACHINES),
      .TIME_BITS(TIME_BITS)) u_dp (
      .clock(clock), .wr_en(accept && (req_req_type == REQ_WRITE)),
      .wr_job(req_job_index),
      .wr_mach(req_machine_index), .wr_proc(req_processing_time),
      .wr_setup(req_setup_time), .run_jobs(run_jobs_ff), .run_machs(run_machs_ff),
      .cmd(cmd), .status(status), .out_pos(rsp_position),
      .out_job(rsp_job_number), .out_best(rsp_best_makespan));

   afs_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start),
      .zero_jobs(num_jobs_ff == '0), .out_stall(rsp_stall), .status(status),
      .cmd(cmd), .busy(busy), .out_valid(rsp_valid));

   assign rsp_last_in_run = status.emit_last;

   ap_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("item accepted while emitting");
   ap_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_in_run) |=> !rsp_valid)
      else $error("results continue after last");
endmodule
